// ===== rtl/b2da_pkg.sv =====
// Package with the shared types, constants and functions of the decimal digit converter.
package b2da_pkg;

    localparam int VALUE_W = 32;
    localparam int CHAR_W = 6;
    localparam int BCD_W = 4;
    localparam int DIGITS_DEFAULT = 10;
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    typedef enum logic [1:0] {
        CVT_IDLE,
        CVT_SHIFT,
        CVT_DONE
    } t_cvt_state;

    typedef enum logic {
        EMT_IDLE,
        EMT_RUN
    } t_emt_state;

    // Largest value that fits in the given number of decimal digits.
    function automatic logic [63:0] f_limit(input int digits);
        logic [63:0] p;
        p = 64'd1;
        for (int k = 0; k < digits; k++) begin
            p = p * 64'd10;
        end
        return p - 64'd1;
    endfunction

endpackage

// ===== rtl/b2da_dabble.sv =====
// Bit-serial binary to BCD converter using the shift and add-three method.
module b2da_dabble #(
    parameter int DIGITS = b2da_pkg::DIGITS_DEFAULT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [b2da_pkg::VALUE_W-1:0]         i_value,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [DIGITS*b2da_pkg::BCD_W-1:0]    o_bcd
);

    localparam int VW = b2da_pkg::VALUE_W;
    localparam int BW = DIGITS * b2da_pkg::BCD_W;
    localparam int CNT_W = $clog2(VW);
    localparam logic [63:0] LIMIT = b2da_pkg::f_limit(DIGITS);

    b2da_pkg::t_cvt_state r_state, n_state;
    logic [VW-1:0]    r_bin, n_bin;
    logic [BW-1:0]    r_bcd, n_bcd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [BW-1:0]    bcd_adj;
    logic [VW-1:0]    sat_value;
    logic             accept;
    logic             shifting;
    logic             last_bit;

    assign last_bit = (r_cnt == CNT_W'(VW - 1));

    always_comb begin
        if ({32'd0, i_value} > LIMIT) begin
            sat_value = LIMIT[VW-1:0];
        end else begin
            sat_value = i_value;
        end
    end

    always_comb begin
        for (int k = 0; k < DIGITS; k++) begin
            if (r_bcd[k*4 +: 4] >= 4'd5) begin
                bcd_adj[k*4 +: 4] = r_bcd[k*4 +: 4] + 4'd3;
            end else begin
                bcd_adj[k*4 +: 4] = r_bcd[k*4 +: 4];
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            b2da_pkg::CVT_IDLE: begin
                if (i_valid) begin
                    n_state = b2da_pkg::CVT_SHIFT;
                end
            end
            b2da_pkg::CVT_SHIFT: begin
                if (last_bit) begin
                    n_state = b2da_pkg::CVT_DONE;
                end
            end
            b2da_pkg::CVT_DONE: begin
                if (!i_stall) begin
                    n_state = b2da_pkg::CVT_IDLE;
                end
            end
            default: n_state = b2da_pkg::CVT_IDLE;
        endcase
    end

    always_comb begin
        o_stall  = 1'b1;
        o_valid  = 1'b0;
        accept   = 1'b0;
        shifting = 1'b0;
        unique case (r_state)
            b2da_pkg::CVT_IDLE: begin
                o_stall = 1'b0;
                accept  = i_valid;
            end
            b2da_pkg::CVT_SHIFT: shifting = 1'b1;
            b2da_pkg::CVT_DONE:  o_valid = 1'b1;
            default: o_stall = 1'b1;
        endcase
    end

    always_comb begin
        n_bin = r_bin;
        n_bcd = r_bcd;
        n_cnt = r_cnt;
        if (accept) begin
            n_bin = sat_value;
            n_bcd = '0;
            n_cnt = '0;
        end else if (shifting) begin
            n_bin = {r_bin[VW-2:0], 1'b0};
            n_bcd = {bcd_adj[BW-2:0], r_bin[VW-1]};
            n_cnt = r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= b2da_pkg::CVT_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_bin <= n_bin;
        r_bcd <= n_bcd;
        r_cnt <= n_cnt;
    end

    assign o_bcd = r_bcd;

endmodule

// ===== rtl/b2da_emit.sv =====
// Digit serialiser with leading-zero blanking and a registered output stage.
module b2da_emit #(
    parameter int DIGITS = b2da_pkg::DIGITS_DEFAULT
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [DIGITS*b2da_pkg::BCD_W-1:0]    i_bcd,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [b2da_pkg::CHAR_W-1:0]          o_ascii_char,
    output logic                                 o_last_char
);

    localparam int BW = DIGITS * b2da_pkg::BCD_W;
    localparam int POS_W = $clog2(DIGITS + 1);

    b2da_pkg::t_emt_state r_state, n_state;
    logic [BW-1:0]                 r_bcd, n_bcd;
    logic [POS_W-1:0]              r_pos, n_pos;
    logic                          r_started, n_started;
    logic                          r_out_valid, n_out_valid;
    logic [b2da_pkg::CHAR_W-1:0]   r_char;
    logic                          r_last;
    logic [3:0]                    digit;
    logic                          is_last;
    logic                          show;
    logic                          out_free;
    logic                          accept;
    logic                          load;
    logic                          step;

    assign digit    = r_bcd[BW-1 -: 4];
    assign is_last  = (r_pos == POS_W'(DIGITS - 1));
    assign show     = (digit != 4'd0) || r_started || is_last;
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            b2da_pkg::EMT_IDLE: begin
                if (i_valid) begin
                    n_state = b2da_pkg::EMT_RUN;
                end
            end
            b2da_pkg::EMT_RUN: begin
                if (is_last && (!show || out_free)) begin
                    n_state = b2da_pkg::EMT_IDLE;
                end
            end
            default: n_state = b2da_pkg::EMT_IDLE;
        endcase
    end

    always_comb begin
        o_stall = 1'b1;
        accept  = 1'b0;
        load    = 1'b0;
        step    = 1'b0;
        unique case (r_state)
            b2da_pkg::EMT_IDLE: begin
                o_stall = 1'b0;
                accept  = i_valid;
            end
            b2da_pkg::EMT_RUN: begin
                load = show && out_free;
                step = !show || out_free;
            end
            default: o_stall = 1'b1;
        endcase
    end

    always_comb begin
        n_bcd       = r_bcd;
        n_pos       = r_pos;
        n_started   = r_started;
        n_out_valid = out_free ? load : r_out_valid;
        if (accept) begin
            n_bcd     = i_bcd;
            n_pos     = '0;
            n_started = 1'b0;
        end else if (step) begin
            n_bcd     = r_bcd << 4;
            n_pos     = r_pos + POS_W'(1);
            n_started = r_started || show;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= b2da_pkg::EMT_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_bcd     <= n_bcd;
        r_pos     <= n_pos;
        r_started <= n_started;
        if (load) begin
            r_char <= b2da_pkg::ASCII_ZERO + {2'b00, digit};
            r_last <= is_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_ascii_char = r_char;
    assign o_last_char  = r_last;

endmodule

// ===== rtl/binary_to_decimal_ascii_digits_core.sv =====
// Top level of the binary to decimal ASCII digit converter.
// The input channel takes one unsigned 32-bit number per transaction on i_value.
// The output channel gives one ASCII digit per transaction, most significant
// first, with leading zeros blanked; o_last_char marks the final digit.
// Zero gives a single '0', and a value above 10^DIGITS-1 gives DIGITS nines.
// Conversion runs bit-serially through a shift and add-three register, one
// input bit per cycle. The digits are then shifted out one per cycle; a
// blanked zero steps on even under a stall, but a shown digit waits while
// the output register is stalled. Conversion of the next number overlaps
// with the output of the current one.
// A stall on the output holds the registered character; the serialiser waits,
// and once the converter has finished it stalls the input channel in turn.
// A synchronous reset empties both stages and the output register.
module binary_to_decimal_ascii_digits_core #(
    parameter int DIGITS = b2da_pkg::DIGITS_DEFAULT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [b2da_pkg::VALUE_W-1:0]   i_value,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [b2da_pkg::CHAR_W-1:0]    o_ascii_char,
    output logic                           o_last_char
);

    localparam int BW = DIGITS * b2da_pkg::BCD_W;

    logic          bcd_valid;
    logic          bcd_stall;
    logic [BW-1:0] bcd;

    b2da_dabble #(
        .DIGITS (DIGITS)
    ) u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_value (i_value),
        .o_valid (bcd_valid),
        .i_stall (bcd_stall),
        .o_bcd   (bcd)
    );

    b2da_emit #(
        .DIGITS (DIGITS)
    ) u_emit (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (bcd_valid),
        .o_stall      (bcd_stall),
        .i_bcd        (bcd),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_ascii_char (o_ascii_char),
        .o_last_char  (o_last_char)
    );

endmodule
